// ===== src/rbhu_pkg.sv =====
// rbhu_pkg: field positions and constants for the readout block hit unpacker
// no dependencies; used by readout_block_hit_unpacker

package rbhu_pkg;

    // default width of the running hit index
    localparam int HIT_INDEX_BITS_DEF = 16;

    // readout word width and data word counter width
    localparam int WORD_BITS = 32;
    localparam int COUNT_BITS = 10;

    // header word fields
    localparam int HDR_MODULE_LSB = 28;
    localparam int HDR_CABLE_LSB = 24;
    localparam int HDR_COUNT_BITS = 9;

    // first data word fields
    localparam int TAC_ADDR_LSB = 27;
    localparam int TAC_CHAN_LSB = 22;
    localparam int CAL_LSB = 18;
    localparam int CLOCK_LSB = 12;

    // result field widths
    localparam int ID_BITS = 4;
    localparam int TAC_ADDR_BITS = 5;
    localparam int TAC_CHAN_BITS = 5;
    localparam int CAL_BITS = 4;
    localparam int CLOCK_BITS = 6;
    localparam int VALUE_BITS = 12;

    // result bits before the hit index
    localparam int HIT_FIXED_BITS = 2 * ID_BITS + TAC_ADDR_BITS + TAC_CHAN_BITS + CAL_BITS
                                  + CLOCK_BITS + 2 * VALUE_BITS;

    // inversion constants for clock and tac values
    localparam logic [CLOCK_BITS-1:0] CLOCK_MAX = 6'd63;
    localparam logic [VALUE_BITS-1:0] TAC_MAX = 12'd4095;

endpackage

// ===== src/readout_block_hit_unpacker.sv =====
// readout_block_hit_unpacker: parses header and data word pairs into hit records
// depends on rbhu_pkg for field positions and widths
//
// output: a hit appears on m_tdata in the cycle after the second word of its pair is accepted
// throughput: one readout word per cycle; s_tready drops only while a hit waits on m_tready
// reset: synchronous active-low aresetn; parser expects a header, hit count cleared,
//        output channel empty

module readout_block_hit_unpacker #(
    parameter int HIT_INDEX_BITS = rbhu_pkg::HIT_INDEX_BITS_DEF,
    localparam int OUT_BITS = rbhu_pkg::HIT_FIXED_BITS + HIT_INDEX_BITS,
    localparam int OUT_TDATA_BITS = 8 * ((OUT_BITS + 7) / 8)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [31:0]               s_tdata,   // word[31:0]
    input  logic                      s_tlast,   // end_of_buffer
    // hit stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // module_id[3:0], cable_id[7:4], tac_address[12:8], tac_channel[17:13],
    // cal_bits[21:18], clock_value[27:22], tac_value[39:28], qdc_value[51:40],
    // hit_index[52 +: HIT_INDEX_BITS], zero fill above
    output logic [OUT_TDATA_BITS-1:0] m_tdata
);

    localparam int IDB = rbhu_pkg::ID_BITS;
    localparam int CNTB = rbhu_pkg::COUNT_BITS;
    localparam logic [HIT_INDEX_BITS-1:0] HIT_MAX = '1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    phase_t                                phase_reg, phase_next;
    logic [CNTB-1:0]                       words_left_reg, words_left_next;
    logic [IDB-1:0]                        module_id_reg, module_id_next;
    logic [IDB-1:0]                        cable_id_reg, cable_id_next;
    logic [rbhu_pkg::WORD_BITS-1:0]        first_word_reg, first_word_next;
    logic [HIT_INDEX_BITS-1:0]             hit_count_reg, hit_count_next;
    logic                                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_BITS-1:0]             m_tdata_reg, m_tdata_next;

    logic                                  in_xfer;
    logic                                  hit_emit;
    logic [CNTB-1:0]                       words_dec;
    logic [CNTB-1:0]                       hdr_count;
    logic [OUT_BITS-1:0]                   hit_bits;

    // accept while the output register is free or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_xfer = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    assign words_dec = words_left_reg - CNTB'(1);
    assign hdr_count = CNTB'(s_tdata[rbhu_pkg::HDR_COUNT_BITS-1:0]);

    // hit record from the held first word and the current second word
    assign hit_bits = {
        hit_count_reg,
        s_tdata[rbhu_pkg::VALUE_BITS-1:0],
        rbhu_pkg::TAC_MAX - first_word_reg[rbhu_pkg::VALUE_BITS-1:0],
        rbhu_pkg::CLOCK_MAX - first_word_reg[rbhu_pkg::CLOCK_LSB +: rbhu_pkg::CLOCK_BITS],
        first_word_reg[rbhu_pkg::CAL_LSB +: rbhu_pkg::CAL_BITS],
        first_word_reg[rbhu_pkg::TAC_CHAN_LSB +: rbhu_pkg::TAC_CHAN_BITS],
        first_word_reg[rbhu_pkg::TAC_ADDR_LSB +: rbhu_pkg::TAC_ADDR_BITS],
        cable_id_reg,
        module_id_reg
    };

    // parser next state
    always_comb begin
        phase_next = phase_reg;
        words_left_next = words_left_reg;
        module_id_next = module_id_reg;
        cable_id_next = cable_id_reg;
        first_word_next = first_word_reg;
        hit_count_next = hit_count_reg;
        hit_emit = 1'b0;
        if (in_xfer) begin
            unique case (phase_reg)
                PH_FIRST: begin
                    first_word_next = s_tdata;
                    words_left_next = words_dec;
                    phase_next = PH_SECOND;
                end
                PH_SECOND: begin
                    hit_emit = 1'b1;
                    if (hit_count_reg != HIT_MAX) begin
                        hit_count_next = hit_count_reg + HIT_INDEX_BITS'(1);
                    end
                    words_left_next = words_dec;
                    phase_next = (words_dec != '0) ? PH_FIRST : PH_HEADER;
                end
                default: begin
                    // header word, also the unused phase code
                    module_id_next = s_tdata[rbhu_pkg::HDR_MODULE_LSB +: IDB];
                    cable_id_next = s_tdata[rbhu_pkg::HDR_CABLE_LSB +: IDB];
                    words_left_next = (hdr_count + CNTB'(1)) & ~CNTB'(1);
                    phase_next = (words_left_next != '0) ? PH_FIRST : PH_HEADER;
                end
            endcase
            // end of buffer returns to header parsing
            if (s_tlast) begin
                phase_next = PH_HEADER;
                words_left_next = '0;
            end
        end
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next = m_tdata_reg;
        if (hit_emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next = OUT_TDATA_BITS'(hit_bits);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            words_left_reg <= '0;
            module_id_reg <= '0;
            cable_id_reg <= '0;
            first_word_reg <= '0;
            hit_count_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            words_left_reg <= words_left_next;
            module_id_reg <= module_id_next;
            cable_id_reg <= cable_id_next;
            first_word_reg <= first_word_next;
            hit_count_reg <= hit_count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

endmodule
